FILE: rtl/sorted_table_search_assert.svh
// Assertion macros used by the checker of the search block.
`ifndef SORTED_TABLE_SEARCH_ASSERT_SVH
`define SORTED_TABLE_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("search block assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("search block assertion failed");

`endif

FILE: rtl/sts_pkg.sv
package sts_pkg;

  localparam int TableDepth = 1024;
  localparam int AddrW      = 10;
  localparam int ValueW     = 32;
  localparam int CntW       = 11;
  localparam int IdxW       = AddrW + 2;
  localparam int NumW       = ValueW + 1;
  localparam int ProdW      = NumW + AddrW;
  localparam int StepW      = 4;
  localparam int PaddrW     = 3;
  localparam int PdataW     = 32;

  localparam logic [PaddrW-1:0] RegMethodAddr = 3'd0;
  localparam logic [StepW-1:0]  DivFirstStep  = StepW'(AddrW - 1);

  typedef enum logic [1:0] {
    METH_SEQ = 2'd0,
    METH_BIN = 2'd1,
    METH_INT = 2'd2
  } method_e;

  typedef enum logic {
    OPC_LOAD   = 1'b0,
    OPC_SEARCH = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEQ_CHK,
    ST_SEQ_CMP,
    ST_BIN_CHK,
    ST_BIN_CMP,
    ST_INT_CHK,
    ST_INT_RDHI,
    ST_INT_COND,
    ST_INT_DIV,
    ST_INT_RDJ,
    ST_INT_UPD,
    ST_INT_FIN_RD,
    ST_INT_FIN,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_INIT,
    OP_SEQ_NEXT,
    OP_HIT_LO,
    OP_SET_MID,
    OP_HIT_MID,
    OP_BIN_UPD,
    OP_CAP_VL,
    OP_INT_SETUP,
    OP_DIV_STEP,
    OP_SET_J,
    OP_INT_UPD,
    OP_INT_FIN,
    OP_OUT_LOAD
  } dp_op_e;

  typedef enum logic [1:0] {
    RD_LO,
    RD_HI,
    RD_MID,
    RD_J
  } rd_sel_e;

  typedef struct packed {
    dp_op_e  op;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic lo_gt_hi;
    logic eq;
    logic int_go;
    logic div_last;
  } status_t;

endpackage

FILE: rtl/sts_ctrl.sv
module sts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [1:0]        method_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  sts_pkg::status_t  status_i,
  output sts_pkg::cmd_t     cmd_o
);

  sts_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sts_pkg::ST_IDLE: begin
        if (in_valid_i && opcode_i == sts_pkg::OPC_SEARCH) begin
          unique case (method_i)
            sts_pkg::METH_SEQ: state_d = sts_pkg::ST_SEQ_CHK;
            sts_pkg::METH_INT: state_d = sts_pkg::ST_INT_CHK;
            default:           state_d = sts_pkg::ST_BIN_CHK;
          endcase
        end
      end
      sts_pkg::ST_SEQ_CHK:
        state_d = status_i.lo_gt_hi ? sts_pkg::ST_DONE : sts_pkg::ST_SEQ_CMP;
      sts_pkg::ST_SEQ_CMP:
        state_d = status_i.eq ? sts_pkg::ST_DONE : sts_pkg::ST_SEQ_CHK;
      sts_pkg::ST_BIN_CHK:
        state_d = status_i.lo_gt_hi ? sts_pkg::ST_DONE : sts_pkg::ST_BIN_CMP;
      sts_pkg::ST_BIN_CMP:
        state_d = status_i.eq ? sts_pkg::ST_DONE : sts_pkg::ST_BIN_CHK;
      sts_pkg::ST_INT_CHK:
        state_d = status_i.lo_gt_hi ? sts_pkg::ST_INT_FIN_RD : sts_pkg::ST_INT_RDHI;
      sts_pkg::ST_INT_RDHI:   state_d = sts_pkg::ST_INT_COND;
      sts_pkg::ST_INT_COND:
        state_d = status_i.int_go ? sts_pkg::ST_INT_DIV : sts_pkg::ST_INT_FIN_RD;
      sts_pkg::ST_INT_DIV:
        state_d = status_i.div_last ? sts_pkg::ST_INT_RDJ : sts_pkg::ST_INT_DIV;
      sts_pkg::ST_INT_RDJ:    state_d = sts_pkg::ST_INT_UPD;
      sts_pkg::ST_INT_UPD:    state_d = sts_pkg::ST_INT_CHK;
      sts_pkg::ST_INT_FIN_RD: state_d = sts_pkg::ST_INT_FIN;
      sts_pkg::ST_INT_FIN:    state_d = sts_pkg::ST_DONE;
      sts_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = sts_pkg::ST_IDLE;
        end
      end
      default: state_d = sts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.op      = sts_pkg::OP_NONE;
    cmd_o.rd_sel  = sts_pkg::RD_LO;
    out_valid_d   = out_ready_i ? 1'b0 : out_valid_q;
    unique case (state_q)
      sts_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = (opcode_i == sts_pkg::OPC_LOAD) ? sts_pkg::OP_WRITE : sts_pkg::OP_INIT;
        end
      end
      sts_pkg::ST_SEQ_CHK: cmd_o.rd_sel = sts_pkg::RD_LO;
      sts_pkg::ST_SEQ_CMP:
        cmd_o.op = status_i.eq ? sts_pkg::OP_HIT_LO : sts_pkg::OP_SEQ_NEXT;
      sts_pkg::ST_BIN_CHK: begin
        cmd_o.rd_sel = sts_pkg::RD_MID;
        cmd_o.op     = sts_pkg::OP_SET_MID;
      end
      sts_pkg::ST_BIN_CMP:
        cmd_o.op = status_i.eq ? sts_pkg::OP_HIT_MID : sts_pkg::OP_BIN_UPD;
      sts_pkg::ST_INT_CHK: cmd_o.rd_sel = sts_pkg::RD_LO;
      sts_pkg::ST_INT_RDHI: begin
        cmd_o.rd_sel = sts_pkg::RD_HI;
        cmd_o.op     = sts_pkg::OP_CAP_VL;
      end
      sts_pkg::ST_INT_COND:
        cmd_o.op = status_i.int_go ? sts_pkg::OP_INT_SETUP : sts_pkg::OP_NONE;
      sts_pkg::ST_INT_DIV: cmd_o.op = sts_pkg::OP_DIV_STEP;
      sts_pkg::ST_INT_RDJ: begin
        cmd_o.rd_sel = sts_pkg::RD_J;
        cmd_o.op     = sts_pkg::OP_SET_J;
      end
      sts_pkg::ST_INT_UPD:    cmd_o.op = sts_pkg::OP_INT_UPD;
      sts_pkg::ST_INT_FIN_RD: cmd_o.rd_sel = sts_pkg::RD_LO;
      sts_pkg::ST_INT_FIN:    cmd_o.op = sts_pkg::OP_INT_FIN;
      sts_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.op    = sts_pkg::OP_OUT_LOAD;
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o.op = sts_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sts_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/sts_dp.sv
module sts_dp (
  input  logic                              clk_i,
  input  sts_pkg::cmd_t                     cmd_i,
  output sts_pkg::status_t                  status_o,
  input  logic [sts_pkg::AddrW-1:0]         write_index_i,
  input  logic signed [sts_pkg::ValueW-1:0] write_value_i,
  input  logic signed [sts_pkg::ValueW-1:0] search_key_i,
  input  logic [sts_pkg::AddrW-1:0]         range_low_i,
  input  logic [sts_pkg::AddrW-1:0]         range_high_i,
  output logic                              found_o,
  output logic [sts_pkg::AddrW-1:0]         position_o,
  output logic [sts_pkg::CntW-1:0]          compare_count_o
);

  logic signed [sts_pkg::ValueW-1:0] mem [sts_pkg::TableDepth];
  logic signed [sts_pkg::ValueW-1:0] rd_q;
  logic signed [sts_pkg::ValueW-1:0] key_q, vl_q;
  logic signed [sts_pkg::IdxW-1:0]   lo_q, hi_q, sum_w, mid_ext;
  logic [sts_pkg::AddrW-1:0]         mid_q, mid_w, j_w, span_w, rd_addr;
  logic [sts_pkg::CntW-1:0]          cnt_q;
  logic                              found_q;
  logic [sts_pkg::AddrW-1:0]         pos_q;
  logic [sts_pkg::NumW-1:0]          num_w, den_q;
  logic [sts_pkg::ProdW-1:0]         rem_q, trial_w;
  logic [sts_pkg::AddrW-1:0]         quot_q;
  logic [sts_pkg::StepW-1:0]         step_q;
  logic                              key_gt;

  assign sum_w   = lo_q + hi_q;
  assign mid_w   = sum_w[sts_pkg::AddrW:1];
  assign j_w     = lo_q[sts_pkg::AddrW-1:0] + quot_q;
  assign span_w  = hi_q[sts_pkg::AddrW-1:0] - lo_q[sts_pkg::AddrW-1:0];
  assign mid_ext = $signed({2'b00, mid_q});
  assign num_w   = {key_q[sts_pkg::ValueW-1], key_q} - {vl_q[sts_pkg::ValueW-1], vl_q};
  assign trial_w = sts_pkg::ProdW'(den_q) << step_q;
  assign key_gt  = key_q > rd_q;

  always_comb begin
    case (cmd_i.rd_sel)
      sts_pkg::RD_LO:  rd_addr = lo_q[sts_pkg::AddrW-1:0];
      sts_pkg::RD_HI:  rd_addr = hi_q[sts_pkg::AddrW-1:0];
      sts_pkg::RD_MID: rd_addr = mid_w;
      default:         rd_addr = j_w;
    endcase
  end

  assign status_o.lo_gt_hi = lo_q > hi_q;
  assign status_o.eq       = rd_q == key_q;
  assign status_o.int_go   = (rd_q >= key_q) && (key_q > vl_q);
  assign status_o.div_last = step_q == '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sts_pkg::OP_WRITE) begin
      mem[write_index_i] <= write_value_i;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sts_pkg::OP_INIT: begin
        key_q   <= search_key_i;
        lo_q    <= $signed({2'b00, range_low_i});
        hi_q    <= $signed({2'b00, range_high_i});
        cnt_q   <= '0;
        found_q <= 1'b0;
        pos_q   <= '0;
      end
      sts_pkg::OP_SEQ_NEXT: begin
        cnt_q <= cnt_q + 1'b1;
        lo_q  <= lo_q + 1'b1;
      end
      sts_pkg::OP_HIT_LO: begin
        found_q <= 1'b1;
        pos_q   <= lo_q[sts_pkg::AddrW-1:0];
      end
      sts_pkg::OP_SET_MID: mid_q <= mid_w;
      sts_pkg::OP_HIT_MID: begin
        found_q <= 1'b1;
        pos_q   <= mid_q;
      end
      sts_pkg::OP_BIN_UPD: begin
        if (key_gt) begin
          lo_q <= mid_ext + 1'b1;
        end else begin
          hi_q <= mid_ext - 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
      sts_pkg::OP_CAP_VL: vl_q <= rd_q;
      sts_pkg::OP_INT_SETUP: begin
        den_q  <= {rd_q[sts_pkg::ValueW-1], rd_q} - {vl_q[sts_pkg::ValueW-1], vl_q};
        rem_q  <= num_w * span_w;
        quot_q <= '0;
        step_q <= sts_pkg::DivFirstStep;
      end
      sts_pkg::OP_DIV_STEP: begin
        if (rem_q >= trial_w) begin
          rem_q          <= rem_q - trial_w;
          quot_q[step_q] <= 1'b1;
        end
        step_q <= step_q - 1'b1;
      end
      sts_pkg::OP_SET_J: mid_q <= j_w;
      sts_pkg::OP_INT_UPD: begin
        if (key_gt) begin
          lo_q <= mid_ext + 1'b1;
        end else if (key_q < rd_q) begin
          hi_q <= mid_ext - 1'b1;
        end else begin
          lo_q <= mid_ext;
        end
        cnt_q <= cnt_q + 1'b1;
      end
      sts_pkg::OP_INT_FIN: begin
        found_q <= rd_q == key_q;
        pos_q   <= (rd_q == key_q) ? lo_q[sts_pkg::AddrW-1:0] : '0;
      end
      sts_pkg::OP_OUT_LOAD: begin
        found_o         <= found_q;
        position_o      <= pos_q;
        compare_count_o <= cnt_q;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/sorted_table_search.sv
// Search engine over a 1024-entry table of signed 32-bit values.
// The input channel carries two kinds of item: a load item (opcode 0) writes
// write_value at write_index, and a search item (opcode 1) looks for
// search_key between range_low and range_high. Each search yields one result
// item with found, position and compare_count; a load yields none.
// The APB register at address 0 selects sequential, binary or interpolation
// search; it resets to binary search. The table itself is not cleared.
// A load is written in the idle state. An interpolation iteration is paced
// by the single table read port and the 10-step divider.
// The result sits in an output register; the next item is accepted while it
// waits. A search that finishes while the receiver stalls waits until the
// output register is free. Reset empties the output and returns to idle.
module sorted_table_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sts_pkg::PaddrW-1:0]        paddr,
  input  logic [sts_pkg::PdataW-1:0]        pwdata,
  output logic [sts_pkg::PdataW-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [sts_pkg::AddrW-1:0]         write_index_i,
  input  logic signed [sts_pkg::ValueW-1:0] write_value_i,
  input  logic signed [sts_pkg::ValueW-1:0] search_key_i,
  input  logic [sts_pkg::AddrW-1:0]         range_low_i,
  input  logic [sts_pkg::AddrW-1:0]         range_high_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              found_o,
  output logic [sts_pkg::AddrW-1:0]         position_o,
  output logic [sts_pkg::CntW-1:0]          compare_count_o
);

  logic [1:0]       method_q;
  sts_pkg::cmd_t    cmd;
  sts_pkg::status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr == sts_pkg::RegMethodAddr) ?
                  {{(sts_pkg::PdataW-2){1'b0}}, method_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= sts_pkg::METH_BIN;
    end else if (psel && penable && pwrite && paddr == sts_pkg::RegMethodAddr) begin
      method_q <= pwdata[1:0];
    end
  end

  sts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .method_i    (method_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sts_dp u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .write_index_i   (write_index_i),
    .write_value_i   (write_value_i),
    .search_key_i    (search_key_i),
    .range_low_i     (range_low_i),
    .range_high_i    (range_high_i),
    .found_o         (found_o),
    .position_o      (position_o),
    .compare_count_o (compare_count_o)
  );

endmodule

FILE: rtl/sts_checker.sv
`include "sorted_table_search_assert.svh"

module sts_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      opcode_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      found_o,
  input logic [sts_pkg::AddrW-1:0] position_o,
  input logic [sts_pkg::CntW-1:0]  compare_count_o
);

  `STS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  `STS_ASSERT_IMPL(a_miss_pos_zero, clk_i, rst_ni, out_valid_o && !found_o, position_o == '0)

  `STS_ASSERT_NEXT(a_search_busy, clk_i, rst_ni, in_valid_i && in_ready_o && opcode_i == sts_pkg::OPC_SEARCH, !in_ready_o)

  `STS_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, out_valid_o, compare_count_o <= sts_pkg::CntW'(sts_pkg::TableDepth))

endmodule

bind sorted_table_search sts_checker u_sts_checker (.*);
